[rtl/gic_pkg.sv]
// Shared types and codes for the GPIO interrupt event classifier.
// Holds the event record, command, source, kind and register codes.
// Depends on nothing; every other rtl file imports it.
package gic_pkg;

    // command carried in the input item's tuser
    localparam logic [1:0] CMD_IRQ   = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    // interrupt source bits
    localparam int SRC_COUNT  = 8;
    localparam int SRC_SHORT  = 0;
    localparam int SRC_ERASE  = 1;
    localparam int SRC_GPIO   = 4;
    localparam int SRC_TAMPER = 5;
    localparam int SRC_LONG   = 7;

    // event kinds
    localparam logic [3:0] KIND_SHORT      = 4'd0;
    localparam logic [3:0] KIND_ERASE      = 4'd1;
    localparam logic [3:0] KIND_TAMPER     = 4'd2;
    localparam logic [3:0] KIND_LONG       = 4'd3;
    localparam logic [3:0] KIND_HIGH       = 4'd4;
    localparam logic [3:0] KIND_LOW        = 4'd5;
    localparam logic [3:0] KIND_RELEASED   = 4'd6;
    localparam logic [3:0] KIND_PRESSED    = 4'd7;
    localparam logic [3:0] KIND_STILL_HIGH = 4'd8;
    localparam logic [3:0] KIND_STILL_LOW  = 4'd9;
    localparam logic [3:0] KIND_HELD       = 4'd10;

    // configuration register indexes
    localparam logic [1:0] CFG_BUTTON_EN   = 2'd0;
    localparam logic [1:0] CFG_BUTTON_PIN  = 2'd1;
    localparam logic [1:0] CFG_STEADY_MASK = 2'd2;
    localparam logic [1:0] CFG_PERIODIC_EN = 2'd3;

    localparam logic [15:0] SAT16      = 16'hFFFF;
    localparam logic [15:0] REPEAT_GAP = 16'd2;

    typedef struct packed {
        logic        vld;
        logic [3:0]  kind;
        logic [3:0]  pin;
        logic [15:0] seen;
        logic [15:0] reps;
    } t_event;

endpackage

[rtl/gpio_irq_event_classifier.sv]
// Top level of the GPIO interrupt event classifier.
// Instantiates gic_src_lane, gic_pin_lane and gic_merge; uses gic_pkg.
//
// Usage:
//   Input items arrive on the s_axis group: tuser carries the command
//   (interrupt, periodic tick, start baseline), tdata the source byte, the
//   pin levels and the time in seconds. Each accepted item is classified in
//   the cycle it is taken: eight source lanes and one lane per pin compute
//   elapsed time and repeat counts in parallel and update their stamps.
//   The events go out on the m_axis group one per cycle while the receiver
//   is ready, in ascending source and pin order, event kind in tuser, last
//   event with tlast high. Registers are written on the cfg channel, always
//   ready, but only while idle: a rule for the user, not enforced by the block.
// Flow:
//   The events of an accepted item are captured in the merge stage's slot
//   registers, then moved one at a time into the output register. An item
//   causes up to PIN_COUNT + 4 events. The next item is taken once its
//   predecessor's last event has entered the output register, even while
//   that event still waits to be taken.
// Reset and stall:
//   Reset clears registers, stamps, repeat counts and baseline levels to
//   zero. A stalled receiver holds the output register; pending events wait
//   and input stays blocked until they have all moved out.
module gpio_irq_event_classifier
    import gic_pkg::*;
#(
    parameter int PIN_COUNT = 16,
    parameter int TIME_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,   // irq_source[7:0], pin_levels[23:8], now_seconds[55:24]
    input  logic [1:0]  i_s_axis_tuser,   // cmd[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,   // pin_index[3:0], seen_seconds[19:4],
                                          // repeat_count[35:20], zero[39:36]
    output logic [3:0]  o_m_axis_tuser,   // event_kind[3:0]
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int SLOT_COUNT = PIN_COUNT + 4;

    // configuration
    logic        r_button_en;
    logic [3:0]  r_button_pin;
    logic [15:0] r_steady_mask;
    logic        r_periodic_en;

    logic [PIN_COUNT-1:0] r_prev;

    logic                 w_acc;
    logic                 w_process;
    logic                 w_start;
    logic [7:0]           w_src;
    logic [TIME_BITS-1:0] w_now;
    logic [PIN_COUNT-1:0] w_levels;
    logic [15:0]          w_src_seen [SRC_COUNT];
    t_event               w_pin_ev [PIN_COUNT];
    t_event               w_slot [SLOT_COUNT];
    logic                 w_idle;
    t_event               w_oev;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_button_en   <= 1'b0;
            r_button_pin  <= '0;
            r_steady_mask <= '0;
            r_periodic_en <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BUTTON_EN:   r_button_en   <= i_cfg_data[0];
                CFG_BUTTON_PIN:  r_button_pin  <= i_cfg_data[3:0];
                CFG_STEADY_MASK: r_steady_mask <= i_cfg_data;
                CFG_PERIODIC_EN: r_periodic_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // decode the item; a tick stands for the gpio source alone
    assign w_acc     = i_s_axis_tvalid && o_s_axis_tready;
    assign w_start   = w_acc && (i_s_axis_tuser == CMD_START);
    assign w_process = w_acc && ((i_s_axis_tuser == CMD_IRQ) ||
                                 (i_s_axis_tuser == CMD_TICK && r_periodic_en));
    assign w_src     = (i_s_axis_tuser == CMD_TICK) ? 8'(1 << SRC_GPIO)
                                                    : i_s_axis_tdata[7:0];
    assign w_now     = TIME_BITS'(i_s_axis_tdata[55:24]);
    assign w_levels  = i_s_axis_tdata[8 +: PIN_COUNT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
        end else if (w_process || w_start) begin
            r_prev <= w_levels;
        end
    end

    for (genvar i = 0; i < SRC_COUNT; i++) begin : g_src
        gic_src_lane #(
            .TIME_BITS(TIME_BITS)
        ) u_src (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_hit   (w_process && w_src[i]),
            .i_start (w_start),
            .i_now   (w_now),
            .o_seen  (w_src_seen[i])
        );
    end

    for (genvar j = 0; j < PIN_COUNT; j++) begin : g_pin
        logic w_is_pb;
        assign w_is_pb = r_button_en && (r_button_pin == 4'(j));
        gic_pin_lane #(
            .TIME_BITS(TIME_BITS),
            .LANE     (j)
        ) u_pin (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_act    (w_process && w_src[SRC_GPIO]),
            .i_start  (w_start),
            .i_level  (w_levels[j]),
            .i_prev   (r_prev[j]),
            .i_steady ((r_steady_mask[j] || w_is_pb) && r_periodic_en),
            .i_is_pb  (w_is_pb),
            .i_now    (w_now),
            .o_ev     (w_pin_ev[j])
        );
        assign w_slot[j + 2] = w_pin_ev[j];
    end

    // slot order follows ascending source bits; pins sit at the gpio bit
    assign w_slot[0] = '{vld: w_process && w_src[SRC_SHORT], kind: KIND_SHORT,
                         pin: 4'd0, seen: w_src_seen[SRC_SHORT], reps: 16'd0};
    assign w_slot[1] = '{vld: w_process && w_src[SRC_ERASE], kind: KIND_ERASE,
                         pin: 4'd0, seen: w_src_seen[SRC_ERASE], reps: 16'd0};
    assign w_slot[PIN_COUNT + 2] = '{vld: w_process && w_src[SRC_TAMPER],
                         kind: KIND_TAMPER, pin: 4'd0,
                         seen: w_src_seen[SRC_TAMPER], reps: 16'd0};
    assign w_slot[PIN_COUNT + 3] = '{vld: w_process && w_src[SRC_LONG],
                         kind: KIND_LONG, pin: 4'd0,
                         seen: w_src_seen[SRC_LONG], reps: 16'd0};

    gic_merge #(
        .SLOT_COUNT(SLOT_COUNT)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_acc),
        .i_ev    (w_slot),
        .o_idle  (w_idle),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_ev    (w_oev),
        .o_last  (o_m_axis_tlast)
    );

    assign o_s_axis_tready = w_idle;
    assign o_m_axis_tuser  = w_oev.kind;
    // hold vld unused on the way out: the output register carries its own valid
    assign o_m_axis_tdata  = {4'b0, w_oev.reps, w_oev.seen, w_oev.pin};

endmodule

[rtl/gic_src_lane.sv]
// One interrupt source lane: holds the source time stamp and reports the
// saturated seconds since it was last seen. Uses gic_pkg for SAT16.
module gic_src_lane
    import gic_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_hit,
    input  logic                 i_start,
    input  logic [TIME_BITS-1:0] i_now,
    output logic [15:0]          o_seen
);

    logic [TIME_BITS-1:0] r_stamp;
    logic [TIME_BITS-1:0] w_diff;

    assign w_diff = i_now - r_stamp;
    assign o_seen = (w_diff > TIME_BITS'(SAT16)) ? SAT16 : w_diff[15:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp <= '0;
        end else if (i_hit || i_start) begin
            r_stamp <= i_now;
        end
    end

endmodule

[rtl/gic_pin_lane.sv]
// One pin lane: holds the pin's time stamp and repeat count and classifies
// the pin for the current item. Uses gic_pkg for kinds and t_event.
module gic_pin_lane
    import gic_pkg::*;
#(
    parameter int TIME_BITS = 32,
    parameter int LANE      = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_act,      // gpio source processed this cycle
    input  logic                 i_start,
    input  logic                 i_level,
    input  logic                 i_prev,
    input  logic                 i_steady,   // in mask or button pin, and periodic mode on
    input  logic                 i_is_pb,
    input  logic [TIME_BITS-1:0] i_now,
    output t_event               o_ev
);

    logic [TIME_BITS-1:0] r_stamp;
    logic [15:0]          r_reps;
    logic [15:0]          n_reps;
    logic [TIME_BITS-1:0] w_diff;
    logic [15:0]          w_seen;
    logic                 w_changed;
    logic                 w_upd;

    assign w_changed = i_level ^ i_prev;
    assign w_upd     = i_act && (w_changed || i_steady);
    assign w_diff    = i_now - r_stamp;
    assign w_seen    = (w_diff > TIME_BITS'(SAT16)) ? SAT16 : w_diff[15:0];

    always_comb begin
        if (w_seen < REPEAT_GAP) begin
            n_reps = (r_reps == SAT16) ? r_reps : r_reps + 16'd1;
        end else begin
            n_reps = '0;
        end
    end

    always_comb begin
        o_ev.pin  = 4'(LANE);
        o_ev.seen = w_seen;
        o_ev.reps = n_reps;
        // button held high on a tick updates state but stays silent
        o_ev.vld  = i_act && (w_changed || (i_steady && !(i_is_pb && i_level)));
        if (w_changed) begin
            if (i_is_pb) begin
                o_ev.kind = i_level ? KIND_RELEASED : KIND_PRESSED;
            end else begin
                o_ev.kind = i_level ? KIND_HIGH : KIND_LOW;
            end
        end else if (i_is_pb) begin
            o_ev.kind = KIND_HELD;
        end else begin
            o_ev.kind = i_level ? KIND_STILL_HIGH : KIND_STILL_LOW;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp <= '0;
            r_reps  <= '0;
        end else if (i_start) begin
            r_stamp <= i_now;
            r_reps  <= '0;
        end else if (w_upd) begin
            r_stamp <= i_now;
            r_reps  <= n_reps;
        end
    end

endmodule

[rtl/gic_merge.sv]
// Merging stage: captures the events of all lanes for one item and sends
// them out lowest slot first through an output register. Uses gic_pkg.
module gic_merge
    import gic_pkg::*;
#(
    parameter int SLOT_COUNT = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_event      i_ev [SLOT_COUNT],
    output logic        o_idle,
    output logic        o_valid,
    input  logic        i_ready,
    output t_event      o_ev,
    output logic        o_last
);

    localparam int SW = $clog2(SLOT_COUNT);

    logic [SLOT_COUNT-1:0] r_pend;
    t_event                r_slot [SLOT_COUNT];
    logic                  r_ovalid;
    t_event                r_oev;
    logic                  r_olast;

    logic [SW-1:0]         w_sel;
    logic [SLOT_COUNT-1:0] w_rest;
    logic                  w_move;

    // lowest pending slot goes next
    always_comb begin
        w_sel = '0;
        for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
            if (r_pend[k]) begin
                w_sel = SW'(k);
            end
        end
    end

    always_comb begin
        w_rest        = r_pend;
        w_rest[w_sel] = 1'b0;
    end

    assign w_move  = (r_pend != '0) && (!r_ovalid || i_ready);
    assign o_idle  = (r_pend == '0);
    assign o_valid = r_ovalid;
    assign o_ev    = r_oev;
    assign o_last  = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_load) begin
                for (int k = 0; k < SLOT_COUNT; k++) begin
                    r_pend[k] <= i_ev[k].vld;
                end
            end else if (w_move) begin
                r_pend <= w_rest;
            end
            if (w_move) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_ev;
        end
        if (w_move) begin
            r_oev   <= r_slot[w_sel];
            r_olast <= (w_rest == '0);
        end
    end

`ifndef SYNTHESIS
    a_load_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_pend == '0))
        else $error("item loaded while events still pending");
    a_one_per_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_move |=> ($countones(r_pend) + 1 == $countones($past(r_pend))))
        else $error("pending set did not drop by one event");
    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_move && (w_rest == '0)) |=> (r_ovalid && r_olast && r_pend == '0))
        else $error("last event not marked or pending not drained");
    a_more_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !r_olast) |-> (r_pend != '0))
        else $error("non-final event with nothing pending");
`endif

endmodule

[dv/gpio_irq_event_classifier_tb.sv]
// Self-checking testbench for gpio_irq_event_classifier: directed corner items, then
// random phases under several register settings with random stalls on both streams.
// Depends on rtl/gic_pkg.sv and the classifier RTL; nothing else.
`timescale 1ns / 100ps

module gpio_irq_event_classifier_tb;
    import gic_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;   // not decoded, the block drops it
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 62;
    localparam int CLIMB_TICKS   = 20;
    localparam int REPORT_CAP    = 40;

    typedef struct packed {
        logic [3:0]  kind;
        logic [3:0]  pin;
        logic [15:0] seen;
        logic [15:0] reps;
        logic        last;
    } t_owed_event;

    // Mirror of the classifier state; owes the events each accepted item must cause.
    class event_ledger;
        logic        btn_en;
        logic [3:0]  btn_pin;
        logic [15:0] steady;
        logic        periodic;
        logic [15:0] prev_levels;
        logic [31:0] pin_stamp [16];
        logic [15:0] pin_reps [16];
        logic [31:0] src_stamp [8];
        t_owed_event owed [$];
        int          mismatches;

        function new();
            btn_en      = 1'b0;
            btn_pin     = '0;
            steady      = '0;
            periodic    = 1'b0;
            prev_levels = '0;
            mismatches  = 0;
            for (int j = 0; j < 16; j++) begin
                pin_stamp[j] = '0;
                pin_reps[j]  = '0;
            end
            for (int i = 0; i < 8; i++) src_stamp[i] = '0;
        endfunction

        function void report(string what);
            if (mismatches < REPORT_CAP) $display("MISMATCH @%0t: %s", $time, what);
            mismatches++;
        endfunction

        // elapsed seconds, wrapping then saturating at 16 bits
        function logic [15:0] age(logic [31:0] now, logic [31:0] stamp);
            logic [31:0] d;
            d = now - stamp;
            return (d > 32'd65535) ? SAT16 : d[15:0];
        endfunction

        function logic [15:0] touch_pin(int j, logic [31:0] now);
            logic [15:0] s;
            s = age(now, pin_stamp[j]);
            pin_stamp[j] = now;
            if (s < REPEAT_GAP) begin
                if (pin_reps[j] != SAT16) pin_reps[j]++;
            end else begin
                pin_reps[j] = '0;
            end
            return s;
        endfunction

        function void owe(logic [3:0] kind, logic [3:0] pin, logic [15:0] seen,
                          logic [15:0] reps);
            t_owed_event e;
            e.kind = kind;
            e.pin  = pin;
            e.seen = seen;
            e.reps = reps;
            e.last = 1'b0;
            owed.push_back(e);
        endfunction

        function void absorb_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                CFG_BUTTON_EN:   btn_en   = val[0];
                CFG_BUTTON_PIN:  btn_pin  = val[3:0];
                CFG_STEADY_MASK: steady   = val;
                CFG_PERIODIC_EN: periodic = val[0];
                default: ;
            endcase
        endfunction

        function void absorb_item(logic [1:0] cmd, logic [7:0] src, logic [15:0] lv,
                                  logic [31:0] now);
            logic [15:0] changed;
            logic [15:0] msk;
            logic [7:0]  bits;
            logic [15:0] s;
            logic        is_btn;
            int          n_prior;
            t_owed_event tail;
            if (cmd == CMD_START) begin
                prev_levels = lv;
                for (int j = 0; j < 16; j++) begin
                    pin_stamp[j] = now;
                    pin_reps[j]  = '0;
                end
                for (int i = 0; i < 8; i++) src_stamp[i] = now;
                return;
            end
            if (cmd == CMD_UNUSED || (cmd == CMD_TICK && !periodic)) return;
            bits = (cmd == CMD_TICK) ? 8'(1 << SRC_GPIO) : src;
            changed = lv ^ prev_levels;
            prev_levels = lv;
            msk = steady;
            if (btn_en) msk[btn_pin] = 1'b1;
            n_prior = owed.size();
            for (int i = 0; i < SRC_COUNT; i++) begin
                if (bits[i]) begin
                    s = age(now, src_stamp[i]);
                    src_stamp[i] = now;
                    case (i)
                        SRC_SHORT:  owe(KIND_SHORT, 4'd0, s, 16'd0);
                        SRC_ERASE:  owe(KIND_ERASE, 4'd0, s, 16'd0);
                        SRC_TAMPER: owe(KIND_TAMPER, 4'd0, s, 16'd0);
                        SRC_LONG:   owe(KIND_LONG, 4'd0, s, 16'd0);
                        SRC_GPIO: begin
                            for (int j = 0; j < 16; j++) begin
                                is_btn = btn_en && (btn_pin == 4'(j));
                                if (changed[j]) begin
                                    s = touch_pin(j, now);
                                    if (is_btn)
                                        owe(lv[j] ? KIND_RELEASED : KIND_PRESSED, 4'(j), s,
                                            pin_reps[j]);
                                    else
                                        owe(lv[j] ? KIND_HIGH : KIND_LOW, 4'(j), s,
                                            pin_reps[j]);
                                end else if (msk[j] && periodic) begin
                                    s = touch_pin(j, now);
                                    // a button resting high refreshes quietly
                                    if (is_btn) begin
                                        if (!lv[j]) owe(KIND_HELD, 4'(j), s, pin_reps[j]);
                                    end else begin
                                        owe(lv[j] ? KIND_STILL_HIGH : KIND_STILL_LOW, 4'(j),
                                            s, pin_reps[j]);
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            if (owed.size() > n_prior) begin
                tail = owed.pop_back();
                tail.last = 1'b1;
                owed.push_back(tail);
            end
        endfunction

        function void match_event(logic [3:0] kind, logic [39:0] data, logic last);
            t_owed_event e;
            if (owed.size() == 0) begin
                report($sformatf("event with nothing owed: kind %0d data %h", kind, data));
                return;
            end
            e = owed.pop_front();
            if (kind !== e.kind)
                report($sformatf("kind %0d, owed %0d (pin %0d)", kind, e.kind, e.pin));
            if (data[3:0] !== e.pin)
                report($sformatf("pin %0d, owed %0d", data[3:0], e.pin));
            if (data[19:4] !== e.seen)
                report($sformatf("seen %0d, owed %0d (pin %0d)", data[19:4], e.seen, e.pin));
            if (data[35:20] !== e.reps)
                report($sformatf("repeats %0d, owed %0d (pin %0d)", data[35:20], e.reps,
                                 e.pin));
            if (data[39:36] !== 4'd0)
                report($sformatf("pad bits %h not zero", data[39:36]));
            if (last !== e.last)
                report($sformatf("tlast %b, owed %b (pin %0d)", last, e.last, e.pin));
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [55:0] i_s_axis_tdata;   // irq_source[7:0], pin_levels[23:8], now_seconds[55:24]
    logic [1:0]  i_s_axis_tuser;   // cmd[1:0]
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [39:0] o_m_axis_tdata;   // pin_index[3:0], seen_seconds[19:4], repeat_count[35:20],
                                   // zero[39:36]
    logic [3:0]  o_m_axis_tuser;   // event_kind[3:0]
    logic        o_m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    event_ledger ledger;
    bit          quiet;      // no idling on either side
    bit          hold_req;   // ask the receiver for one long hold-off

    gpio_irq_event_classifier uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #30_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Receiver: random stall bursts, one long hold-off on request, none when quiet.
    initial begin
        forever begin
            if (hold_req) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // Check every event taken off the output stream.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            ledger.match_event(o_m_axis_tuser, o_m_axis_tdata, o_m_axis_tlast);
    end

    // Offer one item and hold it until taken; tvalid stays high for a following item.
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] src,
                             input logic [15:0] lv, input logic [31:0] now);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= cmd;
        i_s_axis_tdata  <= {now, lv, src};
        do @(posedge i_clk); while (!o_s_axis_tready);
        ledger.absorb_item(cmd, src, lv, now);
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        ledger.absorb_reg(idx, val);
    endtask

    // Write all four registers; unused upper data bits carry noise.
    task automatic configure(input logic be, input logic [3:0] bp, input logic [15:0] sm,
                             input logic pe);
        put_reg(CFG_BUTTON_EN, {15'($urandom), be});
        put_reg(CFG_BUTTON_PIN, {12'($urandom), bp});
        put_reg(CFG_STEADY_MASK, sm);
        put_reg(CFG_PERIODIC_EN, {15'($urandom), pe});
        i_cfg_valid <= 1'b0;
    endtask

    // Drop tvalid, wait out every owed event, then let a silent item retire.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (ledger.owed.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [1:0]  cmd;
        logic [7:0]  src;
        logic [15:0] lv;
        logic [31:0] clock_s;
        int          r;

        ledger   = new();
        quiet    = 1'b0;
        hold_req = 1'b0;
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_s_axis_tuser  <= CMD_IRQ;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= CFG_BUTTON_EN;
        i_cfg_data      <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: registers at reset values.
        send_item(CMD_START,  8'h00, 16'h0000, 32'd1000);
        send_item(CMD_IRQ,    8'hFF, 16'hFFFF, 32'd1001);  // every source and every pin
        send_item(CMD_IRQ,    8'h00, 16'h0000, 32'd1001);  // no source: levels only
        send_item(CMD_TICK,   8'h10, 16'h1234, 32'd1002);  // tick with periodic off
        send_item(CMD_UNUSED, 8'hFF, 16'hFFFF, 32'd5);
        send_item(CMD_IRQ,    8'h10, 16'hFFFF, 32'd1002);  // repeat count climbs
        send_item(CMD_IRQ,    8'h10, 16'h0000, 32'd1002);
        send_item(CMD_IRQ,    8'h01, 16'h0000, 32'd0);     // time runs backwards
        send_item(CMD_IRQ,    8'h80, 16'h0000, 32'hFFFF_FFFF);
        send_item(CMD_IRQ,    8'hA3, 16'h0000, 32'h0001_0000);
        send_item(CMD_IRQ,    8'h4C, 16'h0000, 32'd7);     // sources with no event
        drain();

        // Directed: button on the top pin, every pin steady, periodic on.
        configure(1'b1, 4'd15, 16'hFFFF, 1'b1);
        send_item(CMD_TICK, 8'h00, 16'h7FFF, 32'd100);
        send_item(CMD_TICK, 8'h00, 16'h7FFF, 32'd101);     // button held low
        send_item(CMD_TICK, 8'h00, 16'hFFFF, 32'd101);     // button released
        send_item(CMD_TICK, 8'h00, 16'hFFFF, 32'd103);     // button resting high
        send_item(CMD_IRQ,  8'h10, 16'h0000, 32'd104);     // button pressed
        send_item(CMD_TICK, 8'h00, 16'h0000, 32'd104);
        drain();

        // Directed: button on pin zero, empty mask, periodic off.
        configure(1'b1, 4'd0, 16'h0000, 1'b0);
        send_item(CMD_IRQ,  8'h10, 16'h0001, 32'd200);
        send_item(CMD_TICK, 8'h10, 16'h0000, 32'd200);
        send_item(CMD_IRQ,  8'h10, 16'h0000, 32'd200);
        drain();

        // Random phases, each under its own register setting.
        lv      = '0;
        clock_s = 32'd5000;
        for (int p = 0; p < 5; p++) begin
            case (p)
                0: configure(1'($urandom), 4'($urandom), 16'($urandom), 1'b1);
                1: begin
                    configure(1'b1, 4'($urandom), 16'h0000, 1'b1);
                    hold_req = 1'b1;   // let the block back up against a stalled sink
                end
                2: configure(1'b0, 4'd15, 16'hFFFF, 1'b0);
                3: configure(1'b1, 4'($urandom), 16'($urandom), 1'b1);
                default: begin
                    quiet = 1'b1;
                    configure(1'($urandom), 4'($urandom), 16'($urandom), 1'($urandom));
                end
            endcase
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                r = $urandom_range(0, 99);
                cmd = (r < 8) ? CMD_START : (r < 45) ? CMD_TICK :
                      (r < 96) ? CMD_IRQ : CMD_UNUSED;
                r = $urandom_range(0, 9);
                src = (r < 3) ? 8'h10 : (r < 6) ? (8'($urandom) | 8'h10) : 8'($urandom);
                r = $urandom_range(0, 9);
                if (r >= 3 && r < 8) begin
                    lv = lv ^ (16'h1 << $urandom_range(0, 15));
                    if (r >= 6) lv = lv ^ (16'h1 << $urandom_range(0, 15));
                end else if (r >= 8) begin
                    lv = 16'($urandom);
                end
                r = $urandom_range(0, 99);
                if (r < 60)      clock_s = clock_s + 32'($urandom_range(0, 2));
                else if (r < 75) clock_s = clock_s + 32'($urandom_range(3, 70000));
                else if (r < 85) clock_s = $urandom;
                else if (r < 95) clock_s = clock_s - 32'($urandom_range(1, 5));
                else             clock_s = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
                send_item(cmd, src, lv, clock_s);
                if (!quiet && $urandom_range(0, 3) == 0) begin
                    i_s_axis_tvalid <= 1'b0;
                    i_s_axis_tdata  <= 56'({$urandom, $urandom});
                    i_s_axis_tuser  <= 2'($urandom);
                    repeat ($urandom_range(1, 13)) @(posedge i_clk);
                end
            end
            drain();
        end

        // Climb one pin's repeat count with back-to-back ticks at a fixed time.
        configure(1'b0, 4'd0, 16'h0001, 1'b1);
        send_item(CMD_START, 8'h00, 16'h0000, 32'h8000_0000);
        for (int k = 0; k < CLIMB_TICKS; k++)
            send_item(CMD_TICK, 8'h00, 16'h0000, 32'h8000_0000);
        drain();

        if (ledger.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/gic_pkg.sv
rtl/gic_src_lane.sv
rtl/gic_pin_lane.sv
rtl/gic_merge.sv
rtl/gpio_irq_event_classifier.sv
dv/gpio_irq_event_classifier_tb.sv
